// ----- sv/box_blur_3x3_edge_normalized_core_defines.svh -----
// Assertion macros for the 3x3 box blur core.
// Used by box_blur_3x3_edge_normalized_core; no other dependencies.
`ifndef BOX_BLUR_3X3_EDGE_NORMALIZED_CORE_DEFINES_SVH
`define BOX_BLUR_3X3_EDGE_NORMALIZED_CORE_DEFINES_SVH

// Property that must hold at every edge outside reset.
`define BB3_ASSERT(name, clk, rst, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent at one edge implies consequent at the next.
`define BB3_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/bblur3_pkg.sv -----
// Shared types and constants for the 3x3 box blur core.
// No dependencies.
package bblur3_pkg;

  localparam int WIDTH_REG_W  = 11;
  localparam int HEIGHT_REG_W = 13;
  localparam int CFG_DATA_W   = 13;
  localparam int CFG_INDEX_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic [WIDTH_REG_W-1:0]  IMAGE_WIDTH_RST  = 11'd1024;
  localparam logic [HEIGHT_REG_W-1:0] IMAGE_HEIGHT_RST = 13'd768;

  localparam logic CMD_PIXEL = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  localparam int RGB_W   = 24;
  localparam int LINE_W  = 2 * RGB_W;
  localparam int SUM_W   = 12;  // 9 * 255 fits
  localparam int COUNT_W = 4;   // up to 9 pixels in the mean

  typedef logic [RGB_W-1:0] rgb_t;

  typedef struct packed {
    logic       cmd;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;
  } blur_t;

  // which window columns / rows lie inside the image
  typedef struct packed {
    logic col_lo;
    logic col_hi;
    logic row_lo;
    logic row_hi;
  } win_mask_t;

  typedef struct packed {
    logic [SUM_W-1:0]   red;
    logic [SUM_W-1:0]   green;
    logic [SUM_W-1:0]   blue;
    logic [COUNT_W-1:0] count;
  } sums_t;

endpackage

// ----- sv/bblur3_line_store.sv -----
// Line store: two previous rows per column, one write and one registered read.
// Depends on bblur3_pkg.
module bblur3_line_store import bblur3_pkg::*; #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [LINE_W-1:0] rd_data,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [LINE_W-1:0] wr_data
);

  logic [LINE_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/bblur3_window.sv -----
// 3x3 window of pixels and the registered per-channel sums of its in-image part.
// Depends on bblur3_pkg.
module bblur3_window import bblur3_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      shift,
  input  rgb_t      top,
  input  rgb_t      mid,
  input  rgb_t      pix,
  input  win_mask_t mask,
  output sums_t     sums
);

  // cell index = column * 3 + row, column 0 oldest, row 0 top
  rgb_t cells      [9];
  rgb_t cells_next [9];
  logic [8:0] use_cell;
  logic [SUM_W-1:0] col_red [3];
  logic [SUM_W-1:0] col_green [3];
  logic [SUM_W-1:0] col_blue [3];
  logic [1:0] ncol;
  logic [1:0] nrow;
  sums_t sums_next;

  always_comb begin
    for (int k = 0; k < 6; k++) begin
      cells_next[k] = cells[k+3];
    end
    cells_next[6] = top;
    cells_next[7] = mid;
    cells_next[8] = pix;
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      for (int r = 0; r < 3; r++) begin
        use_cell[c*3+r] = !((c == 0 && !mask.col_lo) || (c == 2 && !mask.col_hi) ||
                            (r == 0 && !mask.row_lo) || (r == 2 && !mask.row_hi));
      end
    end
  end

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      col_red[c]   = '0;
      col_green[c] = '0;
      col_blue[c]  = '0;
      for (int r = 0; r < 3; r++) begin
        if (use_cell[c*3+r]) begin
          col_red[c]   = col_red[c]   + SUM_W'(cells_next[c*3+r][23:16]);
          col_green[c] = col_green[c] + SUM_W'(cells_next[c*3+r][15:8]);
          col_blue[c]  = col_blue[c]  + SUM_W'(cells_next[c*3+r][7:0]);
        end
      end
    end
    ncol = 2'd1 + 2'(mask.col_lo) + 2'(mask.col_hi);
    nrow = 2'd1 + 2'(mask.row_lo) + 2'(mask.row_hi);
    sums_next.red   = col_red[0] + col_red[1] + col_red[2];
    sums_next.green = col_green[0] + col_green[1] + col_green[2];
    sums_next.blue  = col_blue[0] + col_blue[1] + col_blue[2];
    sums_next.count = COUNT_W'(ncol) * COUNT_W'(nrow);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < 9; k++) begin
        cells[k] <= '0;
      end
    end else if (shift) begin
      for (int k = 0; k < 9; k++) begin
        cells[k] <= cells_next[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      sums <= sums_next;
    end
  end

endmodule

// ----- sv/bblur3_mean.sv -----
// Rounded mean per channel and the output register of the result channel.
// Depends on bblur3_pkg.
module bblur3_mean import bblur3_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  load,
  input  sums_t sums,
  input  logic  frame_end,
  output logic  free,
  output logic  blur_valid,
  input  logic  blur_stall,
  output blur_t blur
);

  // reciprocals of 3 and 9 scaled by 2^16, exact for the ranges used here
  localparam logic [14:0] DIV3_K      = 15'd21846;
  localparam logic [14:0] DIV9_K      = 15'd7282;
  localparam int          RECIP_SHIFT = 16;

  // (2*sum + n) / (2*n): shift, then divide by 3 or 9 when n is 3, 6 or 9
  function automatic logic [7:0] rounded_mean(input logic [SUM_W-1:0] s,
                                              input logic [COUNT_W-1:0] n);
    logic [SUM_W:0]   x;
    logic [SUM_W:0]   y;
    logic [27:0]      p;
    logic [7:0]       q;
    x = {s, 1'b0} + (SUM_W+1)'(n);
    y = '0;
    p = '0;
    case (n)
      4'd1: q = x[8:1];
      4'd2: q = x[9:2];
      4'd4: q = x[10:3];
      4'd3: begin
        y = x >> 1;
        p = 28'(y) * 28'(DIV3_K);
        q = p[RECIP_SHIFT+7:RECIP_SHIFT];
      end
      4'd6: begin
        y = x >> 2;
        p = 28'(y) * 28'(DIV3_K);
        q = p[RECIP_SHIFT+7:RECIP_SHIFT];
      end
      4'd9: begin
        y = x >> 1;
        p = 28'(y) * 28'(DIV9_K);
        q = p[RECIP_SHIFT+7:RECIP_SHIFT];
      end
      default: q = '0;
    endcase
    return q;
  endfunction

  assign free = !blur_valid || !blur_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      blur_valid <= 1'b0;
    end else if (load) begin
      blur_valid <= 1'b1;
    end else if (!blur_stall) begin
      blur_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      blur.out_red   <= rounded_mean(sums.red, sums.count);
      blur.out_green <= rounded_mean(sums.green, sums.count);
      blur.out_blue  <= rounded_mean(sums.blue, sums.count);
      blur.frame_end <= frame_end;
    end
  end

endmodule

// ----- sv/box_blur_3x3_edge_normalized_core.sv -----
// Channel   Direction  Handshake               Carries
// pix       in         pix_valid / pix_stall   pix_t: cmd, in_red, in_green, in_blue
// blur      out        blur_valid / blur_stall blur_t: out_red/green/blue, frame_end
// cfg       in         cfg_valid / cfg_ready   cfg_index, cfg_data
//
// A pixel goes through the line store read, then the write-back, window shift and sums,
// and, when it yields a result, the mean into the output register. The sequencer takes
// one pixel at a time, so a read never meets a pending write to the same column.
// Reset is synchronous; no clearing pass: line store contents are undefined until written.
// A stalled result holds the output register; the next pixel is still taken, and the
// engine then waits in its last step until the register frees up.
//
// Top level of the 3x3 box blur core.
// Depends on bblur3_pkg, the defines header and the bblur3_* submodules.
`include "box_blur_3x3_edge_normalized_core_defines.svh"

module box_blur_3x3_edge_normalized_core import bblur3_pkg::*; #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   pix_valid,
  output logic                   pix_stall,
  input  pix_t                   pix,
  output logic                   blur_valid,
  input  logic                   blur_stall,
  output blur_t                  blur,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int HW = $clog2(MAX_HEIGHT + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 2);  // input row runs two past the last row

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;  // line store data arriving
  localparam logic [1:0] S_SUM  = 2'd2;  // sums ready, waiting for the output slot

  logic [1:0] state;
  logic [1:0] state_next;

  logic [WIDTH_REG_W-1:0]  image_width;
  logic [HEIGHT_REG_W-1:0] image_height;
  logic [CW-1:0] w_eff;
  logic [HW-1:0] h_eff;

  logic [RW-1:0] in_row;
  logic [CW-1:0] in_col;
  logic [RW-1:0] out_row;
  logic [CW-1:0] out_col;

  rgb_t pix_q;
  logic fe_q;

  logic accept;
  logic cfg_write;
  logic size_write;
  logic emit;
  logic result_free;
  logic load_result;
  logic in_col_wrap;
  logic out_col_wrap;

  logic [LINE_W-1:0] line_rd;
  win_mask_t mask;
  sums_t sums;

  // ---- configuration: clamp the registers to the usable range ----
  always_comb begin
    if (image_width == '0) begin
      w_eff = CW'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
    if (image_height == '0) begin
      h_eff = HW'(1);
    end else if (32'(image_height) > MAX_HEIGHT) begin
      h_eff = HW'(MAX_HEIGHT);
    end else begin
      h_eff = HW'(image_height);
    end
  end

  assign cfg_ready = (state == S_IDLE);
  assign cfg_write = cfg_valid && cfg_ready;
  // only a size register restarts the frame; a spare index changes nothing
  assign size_write = cfg_write && (cfg_index inside {REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});
  // a pending config transfer wins over a pixel in the same cycle
  assign pix_stall = (state != S_IDLE) || cfg_valid;
  assign accept    = pix_valid && !pix_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[HEIGHT_REG_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- window masks and end of frame, from the output position ----
  assign mask.col_lo = (out_col != '0);
  assign mask.col_hi = (32'(out_col) + 32'd1 < 32'(w_eff));
  assign mask.row_lo = (out_row != '0);
  assign mask.row_hi = (32'(out_row) + 32'd1 < 32'(h_eff));

  assign emit = ((32'(in_row) >= 32'd2) || (in_row == RW'(1) && in_col != '0)) &&
                (32'(out_row) < 32'(h_eff));
  assign in_col_wrap  = (32'(in_col) + 32'd1 >= 32'(w_eff));
  assign out_col_wrap = (32'(out_col) + 32'd1 >= 32'(w_eff));

  assign load_result = (state == S_SUM) && result_free;

  // ---- sequencer: one pixel at a time, so line store accesses never overlap ----
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: if (accept) state_next = S_READ;
      S_READ: state_next = emit ? S_SUM : S_IDLE;
      S_SUM:  if (result_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // pixel held for the write-back; zero past the last row or on a flush tick
  always_ff @(posedge clk) begin
    if (accept) begin
      if (32'(in_row) < 32'(h_eff) && pix.cmd == CMD_PIXEL) begin
        pix_q <= {pix.in_red, pix.in_green, pix.in_blue};
      end else begin
        pix_q <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      fe_q <= !mask.row_hi && !mask.col_hi;
    end
  end

  // ---- position counters ----
  always_ff @(posedge clk) begin
    if (rst || size_write || (load_result && fe_q)) begin
      in_row  <= '0;
      in_col  <= '0;
      out_row <= '0;
      out_col <= '0;
    end else begin
      if (state == S_READ) begin
        if (in_col_wrap) begin
          in_col <= '0;
          in_row <= in_row + RW'(1);
        end else begin
          in_col <= in_col + CW'(1);
        end
      end
      if (load_result) begin
        if (out_col_wrap) begin
          out_col <= '0;
          out_row <= out_row + RW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // ---- datapath ----
  bblur3_line_store #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (AW)
  ) u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (in_col[AW-1:0]),
    .rd_data (line_rd),
    .wr_en   (state == S_READ),
    .wr_addr (in_col[AW-1:0]),
    .wr_data ({line_rd[RGB_W-1:0], pix_q})
  );

  bblur3_window u_window (
    .clk   (clk),
    .rst   (rst),
    .shift (state == S_READ),
    .top   (line_rd[LINE_W-1:RGB_W]),
    .mid   (line_rd[RGB_W-1:0]),
    .pix   (pix_q),
    .mask  (mask),
    .sums  (sums)
  );

  bblur3_mean u_mean (
    .clk        (clk),
    .rst        (rst),
    .load       (load_result),
    .sums       (sums),
    .frame_end  (fe_q),
    .free       (result_free),
    .blur_valid (blur_valid),
    .blur_stall (blur_stall),
    .blur       (blur)
  );

  // ---- checks ----
  `BB3_ASSERT_NEXT(a_accept_starts_read, clk, rst, accept, state == S_READ, "accepted pixel did not start a line store read")
  `BB3_ASSERT_NEXT(a_result_loaded, clk, rst, load_result, state == S_IDLE && blur_valid, "result slot free but no result loaded")
  `BB3_ASSERT(a_cols_in_frame, clk, rst, (32'(in_col) < 32'(w_eff)) && (32'(out_col) < 32'(w_eff)), "column counter outside the frame width")
  `BB3_ASSERT_NEXT(a_frame_restart, clk, rst, load_result && fe_q, in_row == '0 && in_col == '0 && out_row == '0 && out_col == '0, "counters not cleared after last pixel of frame")

endmodule
